>>> hw/rtl/qsu_pkg.sv
// Package for the query string unescaper: item types, character codes and
// the small character-class helpers used by the front end.
// Depends on nothing.
`timescale 1ns / 1ps

package qsu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RUN_MAX         = 3;
  localparam int RUN_CW          = $clog2(RUN_MAX + 1);
  localparam int RUN_IW          = $clog2(RUN_MAX);

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Up to three result bytes caused by one input item; byte 0 goes out first.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CW-1:0]       count;
  } run_t;

  typedef enum logic [1:0] {
    ITEM_IDLE,
    ITEM_KEY,
    ITEM_VALUE,
    ITEM_ESC
  } item_phase_t;

  typedef enum logic [1:0] {
    HEX_NONE,
    HEX_FIRST,
    HEX_SECOND
  } hex_phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = c - CH_ZERO;
      return d <= 8'd9;
    end
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = (c & CASE_MASK) - CH_UA;
      return d < 8'd26;
    end
  endfunction

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t       r;
    logic [7:0] d;
    logic [7:0] u;
    begin
      d = c - CH_ZERO;
      u = (c & CASE_MASK) - CH_UA;
      if (d <= 8'd9) begin
        r.ok  = 1'b1;
        r.val = d[3:0];
      end else if (u < 8'd6) begin
        r.ok  = 1'b1;
        r.val = u[3:0] + 4'd10;
      end else begin
        r.ok  = 1'b0;
        r.val = 4'd0;
      end
      return r;
    end
  endfunction

endpackage

>>> hw/rtl/qsu_front.sv
// Front end of the query string unescaper: takes input items, tracks the
// item and escape state and turns each item into a run of result bytes.
// Depends on qsu_pkg.
`timescale 1ns / 1ps

module qsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  qsu_pkg::in_item_t item,
  output logic              run_valid,
  output qsu_pkg::run_t     run
);

  qsu_pkg::item_phase_t item_phase_r, item_phase_nxt;
  qsu_pkg::hex_phase_t  hex_phase_r, hex_phase_nxt;
  logic [7:0]           hex_value_r, hex_value_nxt;
  logic                 hex_pv_r, hex_pv_nxt;

  qsu_pkg::hex_t        hex;
  logic [7:0]           dec_byte;
  logic [7:0]           raw_byte;
  logic                 is_sep;

  // Bytes written when an item is closed by a separator or the end mark.
  function automatic qsu_pkg::run_t close_run(input qsu_pkg::item_phase_t ph);
    qsu_pkg::run_t r;
    begin
      r = '0;
      case (ph)
        qsu_pkg::ITEM_VALUE: begin
          r.bytes[0] = qsu_pkg::CH_QUOTE;
          r.bytes[1] = qsu_pkg::CH_NL;
          r.count    = qsu_pkg::RUN_CW'(2);
        end
        qsu_pkg::ITEM_KEY, qsu_pkg::ITEM_ESC: begin
          r.bytes[0] = qsu_pkg::CH_EQ;
          r.bytes[1] = qsu_pkg::CH_ONE;
          r.bytes[2] = qsu_pkg::CH_NL;
          r.count    = qsu_pkg::RUN_CW'(3);
        end
        default: begin
          r.bytes[0] = qsu_pkg::CH_NL;
          r.count    = qsu_pkg::RUN_CW'(1);
        end
      endcase
      return r;
    end
  endfunction

  function automatic qsu_pkg::run_t emit_run(input qsu_pkg::item_phase_t ph,
                                             input logic [7:0] c);
    qsu_pkg::run_t r;
    begin
      r = '0;
      if (ph == qsu_pkg::ITEM_VALUE) begin
        r.bytes[0] = c;
        r.count    = qsu_pkg::RUN_CW'(1);
      end else if (c == qsu_pkg::CH_EQ) begin
        r.bytes[0] = qsu_pkg::CH_EQ;
        r.bytes[1] = qsu_pkg::CH_QUOTE;
        r.count    = qsu_pkg::RUN_CW'(2);
      end else if (qsu_pkg::is_digit(c)) begin
        // A key may not start with a digit, so it gets an underscore first.
        if (ph == qsu_pkg::ITEM_IDLE || ph == qsu_pkg::ITEM_ESC) begin
          r.bytes[0] = qsu_pkg::CH_US;
          r.bytes[1] = c;
          r.count    = qsu_pkg::RUN_CW'(2);
        end else begin
          r.bytes[0] = c;
          r.count    = qsu_pkg::RUN_CW'(1);
        end
      end else begin
        r.bytes[0] = qsu_pkg::is_letter(c) ? c : qsu_pkg::CH_US;
        r.count    = qsu_pkg::RUN_CW'(1);
      end
      return r;
    end
  endfunction

  function automatic qsu_pkg::item_phase_t emit_phase(input qsu_pkg::item_phase_t ph,
                                                      input logic [7:0] c);
    begin
      if (ph == qsu_pkg::ITEM_VALUE || c == qsu_pkg::CH_EQ) begin
        return qsu_pkg::ITEM_VALUE;
      end
      return qsu_pkg::ITEM_KEY;
    end
  endfunction

  assign hex      = qsu_pkg::hex_of(item.data);
  assign dec_byte = (hex_pv_r && hex.ok) ? {hex_value_r[3:0], hex.val} : hex_value_r;
  assign raw_byte = (item.data == qsu_pkg::CH_PLUS) ? qsu_pkg::CH_SP : item.data;
  assign is_sep   = (item.data == qsu_pkg::CH_AMP) || (item.data == qsu_pkg::CH_NL);

  // Next state.
  always_comb begin
    item_phase_nxt = item_phase_r;
    hex_phase_nxt  = hex_phase_r;
    hex_value_nxt  = hex_value_r;
    hex_pv_nxt     = hex_pv_r;
    if (accept) begin
      if (item.action == qsu_pkg::ACT_END) begin
        item_phase_nxt = qsu_pkg::ITEM_IDLE;
        hex_phase_nxt  = qsu_pkg::HEX_NONE;
        hex_value_nxt  = 8'd0;
        hex_pv_nxt     = 1'b1;
      end else begin
        case (hex_phase_r)
          qsu_pkg::HEX_FIRST: begin
            if (hex.ok) begin
              hex_value_nxt = {4'd0, hex.val};
            end else begin
              hex_pv_nxt = 1'b0;
            end
            hex_phase_nxt = qsu_pkg::HEX_SECOND;
          end
          qsu_pkg::HEX_SECOND: begin
            hex_phase_nxt  = qsu_pkg::HEX_NONE;
            hex_value_nxt  = 8'd0;
            hex_pv_nxt     = 1'b1;
            item_phase_nxt = emit_phase(item_phase_r, dec_byte);
          end
          default: begin
            if (is_sep) begin
              item_phase_nxt = qsu_pkg::ITEM_IDLE;
            end else if (item.data == qsu_pkg::CH_PCT) begin
              hex_phase_nxt = qsu_pkg::HEX_FIRST;
              hex_value_nxt = 8'd0;
              hex_pv_nxt    = 1'b1;
              if (item_phase_r == qsu_pkg::ITEM_IDLE) begin
                item_phase_nxt = qsu_pkg::ITEM_ESC;
              end
            end else begin
              item_phase_nxt = emit_phase(item_phase_r, raw_byte);
            end
          end
        endcase
      end
    end
  end

  // Result bytes for the item on the input.
  always_comb begin
    run = '0;
    if (item.action == qsu_pkg::ACT_END) begin
      run = close_run(item_phase_r);
    end else begin
      case (hex_phase_r)
        qsu_pkg::HEX_FIRST: begin
          run = '0;
        end
        qsu_pkg::HEX_SECOND: begin
          run = emit_run(item_phase_r, dec_byte);
        end
        default: begin
          if (is_sep) begin
            run = close_run(item_phase_r);
          end else if (item.data != qsu_pkg::CH_PCT) begin
            run = emit_run(item_phase_r, raw_byte);
          end
        end
      endcase
    end
    run_valid = accept && (run.count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_phase_r <= qsu_pkg::ITEM_IDLE;
      hex_phase_r  <= qsu_pkg::HEX_NONE;
      hex_value_r  <= 8'd0;
      hex_pv_r     <= 1'b1;
    end else begin
      item_phase_r <= item_phase_nxt;
      hex_phase_r  <= hex_phase_nxt;
      hex_value_r  <= hex_value_nxt;
      hex_pv_r     <= hex_pv_nxt;
    end
  end

  // An open escape always belongs to an item that has begun.
  a_esc_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    hex_phase_r != qsu_pkg::HEX_NONE |-> item_phase_r != qsu_pkg::ITEM_IDLE)
    else $error("escape open outside an item");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.action == qsu_pkg::ACT_END |=>
      item_phase_r == qsu_pkg::ITEM_IDLE && hex_phase_r == qsu_pkg::HEX_NONE && hex_pv_r)
    else $error("end mark did not return state to idle");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.action == qsu_pkg::ACT_DATA && hex_phase_r == qsu_pkg::HEX_FIRST |=>
      hex_phase_r == qsu_pkg::HEX_SECOND)
    else $error("escape skipped its second hex byte");

endmodule

>>> hw/rtl/qsu_queue.sv
// Short queue of result runs between the front end and the back end of the
// query string unescaper.
// Depends on qsu_pkg.
`timescale 1ns / 1ps

module qsu_queue #(
  parameter int DEPTH = qsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  qsu_pkg::run_t wr_run,
  output logic          full,
  input  logic          rd_en,
  output qsu_pkg::run_t rd_run,
  output logic          rd_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qsu_pkg::run_t  entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_wr;
  logic           do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_run   = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_run;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a write");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    do_rd && !do_wr |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a read");

endmodule

>>> hw/rtl/qsu_back.sv
// Back end of the query string unescaper: walks the run at the head of the
// queue and hands its bytes out one per transfer.
// Depends on qsu_pkg.
`timescale 1ns / 1ps

module qsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  qsu_pkg::run_t      head_run,
  output logic               head_done,
  output logic               empty,
  input  logic               pop,
  output qsu_pkg::out_item_t out_item
);

  logic [qsu_pkg::RUN_IW-1:0] idx_r, idx_nxt;
  logic                       is_last;
  logic                       take;

  assign empty   = !head_valid;
  assign is_last = (qsu_pkg::RUN_CW'(idx_r) == head_run.count - 1'b1);
  assign take    = pop && head_valid;

  assign out_item.out_byte    = head_run.bytes[idx_r];
  assign out_item.last_of_run = is_last;

  // The run leaves the queue with the transfer of its final byte.
  assign head_done = take && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> qsu_pkg::RUN_CW'(idx_r) < head_run.count)
    else $error("byte index past end of run");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> idx_r == '0)
    else $error("byte index not at start while queue is empty");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !is_last |=> idx_r == $past(idx_r) + 1'b1)
    else $error("byte index did not advance after a transfer");

endmodule

>>> hw/rtl/query_string_unescaper_unit.sv
// Query string unescaper: each input transfer's run is written into the run
// queue; one input item per cycle while the run queue has room. Each result
// byte takes one output transfer, so items that cause two or three bytes are
// drained by the back end at one byte per cycle while pop is held, and the
// run queue (QUEUE_DEPTH runs) sets how long input continues meanwhile.
// Synchronous active-low reset empties the queue and returns to the idle state.
`timescale 1ns / 1ps

module query_string_unescaper_unit #(
  parameter int QUEUE_DEPTH = qsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  qsu_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output qsu_pkg::out_item_t out_item
);

  logic          in_accept;
  logic          run_valid;
  qsu_pkg::run_t run;
  logic          q_full;
  logic          head_valid;
  qsu_pkg::run_t head_run;
  logic          head_done;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  qsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_item),
    .run_valid (run_valid),
    .run       (run)
  );

  qsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (run_valid),
    .wr_run   (run),
    .full     (q_full),
    .rd_en    (head_done),
    .rd_run   (head_run),
    .rd_valid (head_valid)
  );

  qsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_run   (head_run),
    .head_done  (head_done),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule
